// ----- rtl/fmfr_pkg.sv -----
`default_nettype none

package fmfr_pkg;

  parameter int MAX_PAYLOAD = 256;

  localparam logic [8:0] MaxPayloadW = 9'(MAX_PAYLOAD);

  localparam logic [7:0]  MARK_FOURWAY = 8'h2F;
  localparam logic [7:0]  MARK_DOLLAR  = 8'h24;
  localparam logic [7:0]  MARK_M       = 8'h4D;
  localparam logic [7:0]  MARK_LT      = 8'h3C;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  // Byte positions inside a frame, counted from the start marker.
  localparam logic [8:0] POS_IDLE    = 9'd0;
  localparam logic [8:0] POS_HDR1    = 9'd1;
  localparam logic [8:0] POS_HDR2    = 9'd2;
  localparam logic [8:0] POS_HDR3    = 9'd3;
  localparam logic [8:0] POS_HDR4    = 9'd4;
  localparam logic [8:0] POS_PAYLOAD = 9'd5;

  // Bytes around the payload: four-way has five header and two CRC bytes,
  // MSP v1 has five header bytes and one checksum byte.
  localparam logic [8:0] FOURWAY_OVERHEAD = 9'd7;
  localparam logic [8:0] MSP_OVERHEAD     = 9'd6;

  typedef enum logic [1:0] {
    RK_PAYLOAD = 2'd0,
    RK_OK      = 2'd1,
    RK_REJECT  = 2'd2
  } result_kind_e;

  typedef enum logic {
    FK_FOURWAY = 1'b0,
    FK_MSP     = 1'b1
  } frame_kind_e;

  typedef struct packed {
    result_kind_e kind;
    frame_kind_e  fkind;
    logic [7:0]   command;
    logic [15:0]  address;
    logic [8:0]   count;
    logic [7:0]   data;
  } result_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fmfr_in_stage.sv -----
`default_nettype none

module fmfr_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  input  wire logic       take_i
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign rx_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rx_valid_i && rx_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fmfr_parser.sv -----
`default_nettype none

module fmfr_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output logic                  res_valid_o,
  output fmfr_pkg::result_t     res_o
);

  import fmfr_pkg::*;

  logic [8:0]  byte_index_q, byte_index_d;
  logic [8:0]  frame_total_q, frame_total_d;
  frame_kind_e current_kind_q, current_kind_d;
  logic [15:0] running_crc_q, running_crc_d;
  logic [7:0]  running_xor_q, running_xor_d;
  logic [7:0]  held_command_q, held_command_d;
  logic [15:0] held_address_q, held_address_d;
  logic [8:0]  held_length_q, held_length_d;
  logic        header_good_q, header_good_d;
  logic [7:0]  crc_high_q, crc_high_d;

  logic [8:0]  idx;
  logic [8:0]  fw_len;
  logic        ok;

  assign idx    = byte_index_q;
  assign fw_len = (byte_i == 8'h00) ? 9'd256 : {1'b0, byte_i};

  always_comb begin
    byte_index_d   = byte_index_q;
    frame_total_d  = frame_total_q;
    current_kind_d = current_kind_q;
    running_crc_d  = running_crc_q;
    running_xor_d  = running_xor_q;
    held_command_d = held_command_q;
    held_address_d = held_address_q;
    held_length_d  = held_length_q;
    header_good_d  = header_good_q;
    crc_high_d     = crc_high_q;
    ok             = 1'b0;
    res_valid_o    = 1'b0;
    res_o.kind     = RK_PAYLOAD;
    res_o.fkind    = current_kind_q;
    res_o.command  = held_command_q;
    res_o.address  = held_address_q;
    res_o.count    = held_length_q;
    res_o.data     = byte_i;

    if (idx == POS_IDLE) begin
      if (byte_i == MARK_FOURWAY || byte_i == MARK_DOLLAR) begin
        if (byte_i == MARK_FOURWAY) begin
          current_kind_d = FK_FOURWAY;
          running_crc_d  = crc_feed(16'h0000, byte_i);
        end else begin
          current_kind_d = FK_MSP;
          running_xor_d  = 8'h00;
        end
        held_command_d = 8'h00;
        held_address_d = 16'h0000;
        held_length_d  = 9'd0;
        header_good_d  = 1'b1;
        frame_total_d  = 9'd0;
        byte_index_d   = POS_HDR1;
      end
    end else if (idx < POS_PAYLOAD) begin
      byte_index_d = idx + 9'd1;
      if (current_kind_q == FK_FOURWAY) begin
        running_crc_d = crc_feed(running_crc_q, byte_i);
        case (idx)
          POS_HDR1: held_command_d = byte_i;
          POS_HDR2: held_address_d = {byte_i, held_address_q[7:0]};
          POS_HDR3: held_address_d = {held_address_q[15:8], byte_i};
          default: begin
            held_length_d = fw_len;
            frame_total_d = fw_len + FOURWAY_OVERHEAD;
            if (fw_len > MaxPayloadW) begin
              header_good_d = 1'b0;
            end
          end
        endcase
      end else begin
        case (idx)
          POS_HDR1: begin
            if (byte_i != MARK_M) begin
              header_good_d = 1'b0;
            end
          end
          POS_HDR2: begin
            if (byte_i != MARK_LT) begin
              header_good_d = 1'b0;
            end
          end
          POS_HDR3: begin
            running_xor_d = running_xor_q ^ byte_i;
            held_length_d = {1'b0, byte_i};
            frame_total_d = {1'b0, byte_i} + MSP_OVERHEAD;
            if ({1'b0, byte_i} > MaxPayloadW) begin
              header_good_d = 1'b0;
            end
          end
          default: begin
            running_xor_d  = running_xor_q ^ byte_i;
            held_command_d = byte_i;
          end
        endcase
      end
    end else if ((idx + 9'd1) == frame_total_q) begin
      if (current_kind_q == FK_FOURWAY) begin
        ok = header_good_q && ({crc_high_q, byte_i} == running_crc_q);
      end else begin
        ok = header_good_q && (byte_i == running_xor_q);
      end
      res_valid_o   = 1'b1;
      res_o.kind    = ok ? RK_OK : RK_REJECT;
      res_o.data    = 8'h00;
      byte_index_d  = POS_IDLE;
      frame_total_d = 9'd0;
      running_crc_d = 16'h0000;
      running_xor_d = 8'h00;
      header_good_d = 1'b1;
    end else if (current_kind_q == FK_FOURWAY && (idx + 9'd2) == frame_total_q) begin
      crc_high_d   = byte_i;
      byte_index_d = idx + 9'd1;
    end else begin
      if (current_kind_q == FK_FOURWAY) begin
        running_crc_d = crc_feed(running_crc_q, byte_i);
      end else begin
        running_xor_d = running_xor_q ^ byte_i;
      end
      byte_index_d = idx + 9'd1;
      res_valid_o  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q   <= POS_IDLE;
      frame_total_q  <= 9'd0;
      current_kind_q <= FK_FOURWAY;
      running_crc_q  <= 16'h0000;
      running_xor_q  <= 8'h00;
      held_command_q <= 8'h00;
      held_address_q <= 16'h0000;
      held_length_q  <= 9'd0;
      header_good_q  <= 1'b1;
      crc_high_q     <= 8'h00;
    end else if (step_i) begin
      byte_index_q   <= byte_index_d;
      frame_total_q  <= frame_total_d;
      current_kind_q <= current_kind_d;
      running_crc_q  <= running_crc_d;
      running_xor_q  <= running_xor_d;
      held_command_q <= held_command_d;
      held_address_q <= held_address_d;
      held_length_q  <= held_length_d;
      header_good_q  <= header_good_d;
      crc_high_q     <= crc_high_d;
    end
  end

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_index_q == POS_IDLE) |-> (frame_total_q == 9'd0 && running_crc_q == 16'h0000 &&
                                    running_xor_q == 8'h00 && header_good_q))
    else $error("parser idle with leftover frame state");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_index_q <= (9'd256 + FOURWAY_OVERHEAD - 9'd1))
    else $error("byte index past the longest frame");

  a_summary_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o && res_o.kind != RK_PAYLOAD) |=> (byte_index_q == POS_IDLE))
    else $error("parser did not return to idle after a summary");

  a_total_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_index_q >= POS_PAYLOAD && current_kind_q == FK_FOURWAY) |->
      (frame_total_q >= (FOURWAY_OVERHEAD + 9'd1)))
    else $error("four-way frame length missing in payload phase");

endmodule

`default_nettype wire

// ----- rtl/fmfr_out_stage.sv -----
`default_nettype none

module fmfr_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire fmfr_pkg::result_t res_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output fmfr_pkg::result_t      res_o
);

  import fmfr_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fourway_msp_frame_receiver_core.sv -----
// Path: an accepted byte sits in the input register, and its result loads into the result
// register when the parser steps; the step waits while the result register is full.
// Throughput: one byte per cycle while the result register drains; the CRC byte update is
// a single combinational step between the two registers.
// Reset: rst_ni is asynchronous, active low, and returns the parser to idle with empty
// input and result registers.
`default_nettype none

module fourway_msp_frame_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [1:0]       result_kind_o,
  output logic             frame_kind_o,
  output logic [7:0]       command_code_o,
  output logic [15:0]      target_address_o,
  output logic [8:0]       payload_count_o,
  output logic [7:0]       data_byte_o
);

  import fmfr_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       out_free;
  logic       step;
  logic       parse_valid;
  result_t    parse_res;
  result_t    out_res;

  assign step = stage_valid && out_free;

  fmfr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte),
    .take_i     (step)
  );

  fmfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (stage_byte),
    .res_valid_o (parse_valid),
    .res_o       (parse_res)
  );

  fmfr_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && parse_valid),
    .res_i   (parse_res),
    .free_o  (out_free),
    .valid_o (res_valid_o),
    .ready_i (res_ready_i),
    .res_o   (out_res)
  );

  assign result_kind_o    = out_res.kind;
  assign frame_kind_o     = out_res.fkind;
  assign command_code_o   = out_res.command;
  assign target_address_o = out_res.address;
  assign payload_count_o  = out_res.count;
  assign data_byte_o      = out_res.data;

endmodule

`default_nettype wire
